// ===== hdl/rmsdb_pkg.sv =====
`timescale 1ns / 1ps
package rmsdb_pkg;

    localparam int BLOCK_MAX = 512;
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W     = 40;
    localparam int E_W       = 6;
    localparam int FRAC_W    = 16;
    localparam int LOG_W     = E_W + FRAC_W;
    localparam int MAG_W     = LOG_W + 2;
    localparam int DBC_W     = 26;
    localparam int PROD_W    = LOG_W + DBC_W;

    localparam logic [DBC_W-1:0]  DB_PER_LOG2_Q24 = 26'd50504453;
    localparam logic [MAG_W-1:0]  FULL_SCALE_Q16  = MAG_W'(30 * 65536);
    localparam logic signed [16:0] LEVEL_RESET    = -17'sd30720;
    localparam logic signed [16:0] LEVEL_SILENT   = -17'sd51200;
    localparam logic [16:0]       DB_MAX          = 17'd51200;

    typedef struct packed {
        logic accept;
        logic norm;
        logic sqr;
        logic next;
        logic mul;
        logic rnd;
    } t_cmd;

    typedef struct packed {
        logic calc;
        logic x_top;
        logic sqr_last;
        logic pass;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/rmsdb_if.sv =====
`timescale 1ns / 1ps
interface rmsdb_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] sample;
    logic               last_sample;
    logic [31:0]        now_ms;

    modport source (output valid, cmd, sample, last_sample, now_ms, input ready);
    modport sink   (input valid, cmd, sample, last_sample, now_ms, output ready);
endinterface

interface rmsdb_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] level_db;
    logic               level_updated;

    modport source (output valid, level_db, level_updated, input ready);
    modport sink   (input valid, level_db, level_updated, output ready);
endinterface

// ===== hdl/block_rms_dbfs_level_meter_top.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                    request taken when
// i_in      in   cmd, sample, last_sample, now_ms           valid && ready
// o_out     out  level_db, level_updated                    valid && ready
// i_cfg     in   update_interval_ms (i_cfg_wdata)           i_cfg_we
//
// a request is answered from the output register unless it is a due block end
// with a nonzero sum; that one has its result only after the shared log2 unit
// has run (normalize shifts and squaring steps for the sum, then again for
// the count, then multiply and round)
// reset: synchronous active low, level -120 dB, interval 100 ms
// input is held off while the log2 unit runs and while the output register
// is full and not taken
module block_rms_dbfs_level_meter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    rmsdb_in_if.sink    i_in,
    rmsdb_out_if.source o_out
);
    import rmsdb_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    rmsdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rmsdb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd_bit       (i_in.cmd),
        .i_sample        (i_in.sample),
        .i_last_sample   (i_in.last_sample),
        .i_now_ms        (i_in.now_ms),
        .i_out_ready     (o_out.ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out.valid),
        .o_level_db      (o_out.level_db),
        .o_level_updated (o_out.level_updated)
    );
endmodule

// ===== hdl/rmsdb_ctrl.sv =====
`timescale 1ns / 1ps
module rmsdb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rmsdb_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output rmsdb_pkg::t_cmd o_cmd
);
    import rmsdb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_NORM = 6'b000010,
        S_SQR  = 6'b000100,
        S_NEXT = 6'b001000,
        S_MUL  = 6'b010000,
        S_RND  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
                if (o_cmd.accept && i_stat.calc) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                if (i_stat.x_top) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                if (i_stat.sqr_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state = i_stat.pass ? S_MUL : S_NORM;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hdl/rmsdb_dp.sv =====
`timescale 1ns / 1ps
module rmsdb_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_cmd_bit,
    input  logic signed [15:0] i_sample,
    input  logic               i_last_sample,
    input  logic [31:0]        i_now_ms,
    input  logic               i_out_ready,
    input  rmsdb_pkg::t_cmd    i_cmd,
    output rmsdb_pkg::t_stat   o_stat,
    output logic               o_out_valid,
    output logic signed [16:0] o_level_db,
    output logic               o_level_updated
);
    import rmsdb_pkg::*;

    logic [15:0]        r_interval;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [16:0] r_level;
    logic [31:0]        r_last_time;
    logic [SUM_W-1:0]   r_x;
    logic [E_W-1:0]     r_e;
    logic [31:0]        r_m;
    logic [FRAC_W-1:0]  r_frac;
    logic [3:0]         r_i;
    logic               r_pass;
    logic [CNT_W-1:0]   r_n_hold;
    logic [LOG_W-1:0]   r_log_s;
    logic [LOG_W-1:0]   r_mag;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid;
    logic signed [16:0] r_out_level;
    logic               r_out_upd;

    logic signed [31:0] sq;
    logic               can_acc;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   cnt_new;
    logic [31:0]        elapsed;
    logic               due;
    logic [63:0]        p64;
    logic [32:0]        p;
    logic [MAG_W-1:0]   mag;
    logic [PROD_W:0]    rnd_sum;
    logic [16:0]        db_raw;
    logic [16:0]        db;

    always_comb begin
        sq      = i_sample * i_sample;
        can_acc = (r_cnt != CNT_W'(BLOCK_MAX));
        sum_new = can_acc ? r_sum + {{(SUM_W-32){1'b0}}, sq} : r_sum;
        cnt_new = can_acc ? r_cnt + 1'b1 : r_cnt;
        elapsed = i_now_ms - r_last_time;
        due     = elapsed > {16'd0, r_interval};
        p64     = {32'd0, r_m} * {32'd0, r_m};
        p       = p64[63:31];
        mag     = FULL_SCALE_Q16 - {2'b00, r_log_s} + {2'b00, r_e, r_frac};
        rnd_sum = {1'b0, r_prod} + (PROD_W+1)'(64'd1 << 31);
        db_raw  = rnd_sum[PROD_W:32];
        db      = (db_raw > DB_MAX) ? DB_MAX : db_raw;
    end

    assign o_stat.calc     = !i_cmd_bit && i_last_sample && due && (sum_new != '0);
    assign o_stat.x_top    = r_x[SUM_W-1];
    assign o_stat.sqr_last = (r_i == 4'd0);
    assign o_stat.pass     = r_pass;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_level_db      = r_out_level;
    assign o_level_updated = r_out_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= 16'd100;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_level     <= LEVEL_RESET;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                if (i_cmd_bit) begin
                    r_level     <= LEVEL_RESET;
                    r_last_time <= i_now_ms;
                    r_sum       <= '0;
                    r_cnt       <= '0;
                    r_out_valid <= 1'b1;
                    r_out_level <= LEVEL_RESET;
                    r_out_upd   <= 1'b1;
                end else if (i_last_sample) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                    if (due) begin
                        r_last_time <= i_now_ms;
                        if (sum_new == '0) begin
                            r_level     <= LEVEL_SILENT;
                            r_out_valid <= 1'b1;
                            r_out_level <= LEVEL_SILENT;
                            r_out_upd   <= 1'b1;
                        end
                    end else begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_level;
                        r_out_upd   <= 1'b0;
                    end
                end else begin
                    r_sum       <= sum_new;
                    r_cnt       <= cnt_new;
                    r_out_valid <= 1'b1;
                    r_out_level <= r_level;
                    r_out_upd   <= 1'b0;
                end
            end
            if (i_cmd.rnd) begin
                r_level     <= 17'(-$signed({1'b0, db}));
                r_out_valid <= 1'b1;
                r_out_level <= 17'(-$signed({1'b0, db}));
                r_out_upd   <= 1'b1;
            end
        end
    end

    // log2 unit: normalize, then 16 squaring steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x      <= sum_new;
            r_e      <= E_W'(SUM_W - 1);
            r_pass   <= 1'b0;
            r_n_hold <= cnt_new;
        end
        if (i_cmd.norm) begin
            if (r_x[SUM_W-1]) begin
                r_m    <= r_x[SUM_W-1 -: 32];
                r_frac <= '0;
                r_i    <= 4'd15;
            end else begin
                r_x <= r_x << 1;
                r_e <= r_e - 1'b1;
            end
        end
        if (i_cmd.sqr) begin
            if (p[32]) begin
                r_m         <= p[32:1];
                r_frac[r_i] <= 1'b1;
            end else begin
                r_m <= p[31:0];
            end
            r_i <= r_i - 1'b1;
        end
        if (i_cmd.next) begin
            if (!r_pass) begin
                r_log_s <= {r_e, r_frac};
                r_x     <= {{(SUM_W-CNT_W){1'b0}}, r_n_hold};
                r_e     <= E_W'(SUM_W - 1);
                r_pass  <= 1'b1;
            end else begin
                r_mag <= mag[MAG_W-1] ? '0 : mag[LOG_W-1:0];
            end
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag * DB_PER_LOG2_Q24;
        end
    end
endmodule
